// ----- design/lsdrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lsdrs_pkg
// Shared types, constants and helpers for the 24-bit key LSD radix sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package lsdrs_pkg;

   // record and digit geometry
   localparam int REC_W        = 64;
   localparam int DIGIT_W      = 8;
   localparam int DIGIT_VALUES = 256;
   localparam int BIN_W        = 9;   // bin counter, holds 0..DIGIT_VALUES

   // parameter defaults
   localparam int MAX_RECORDS_DEF  = 1024;
   localparam int DIGIT_PASSES_DEF = 3;

   // request opcodes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD_INC,
      ST_PREFIX,
      ST_SCAT_A,
      ST_SCAT_B,
      ST_RD_WAIT,
      ST_RD_DATA
   } ctl_state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic clr_step;    // zero one histogram row, advance bin
      logic load;        // store a record, read histogram bins
      logic load_inc;    // write back incremented histogram bins
      logic sort_init;   // start pass 0
      logic pfx_step;    // one step of the exclusive prefix sum
      logic scat_a;      // take source record, look up its offset
      logic scat_b;      // write record to destination, bump offset
      logic next_pass;   // move on to the next digit pass
      logic finish;      // sort done
      logic sorting;     // source store is addressed by the scatter index
      logic rd_capture;  // register the response word
   } ctl_cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic clr_last;    // last histogram row being cleared
      logic pfx_end;     // prefix sum has covered all bins
      logic scat_done;   // all records of this pass scattered
      logic pass_last;   // current pass is the final one
      logic sorted;      // current set is sorted
   } ctl_status_type;

   // digit number 'pass' of a record
   function automatic logic [DIGIT_W-1:0] digit_of(input logic [REC_W-1:0] rec,
                                                   input logic [1:0] pass);
      digit_of = rec[{pass, 3'b000} +: DIGIT_W];
   endfunction

endpackage

`default_nettype wire

// ----- design/lsdrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsdrs_ctrl
// Sequencer: histogram clear after reset, load, prefix/scatter passes, read.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_ctrl
   import lsdrs_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic           req_op,
   input  ctl_status_type      status,
   output logic                busy,
   output ctl_cmd_type         cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_op == OP_LOAD) begin
                  cmd.load = 1'b1;
                  state_in = ST_LOAD_INC;
               end else if (status.sorted) begin
                  state_in = ST_RD_WAIT;
               end else begin
                  cmd.sort_init = 1'b1;
                  state_in      = ST_PREFIX;
               end
            end
         end
         ST_LOAD_INC: begin
            cmd.load_inc = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_PREFIX: begin
            cmd.sorting  = 1'b1;
            cmd.pfx_step = 1'b1;
            if (status.pfx_end) begin
               if (!status.scat_done) begin
                  state_in = ST_SCAT_A;
               end else if (status.pass_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_RD_WAIT;
               end else begin
                  cmd.next_pass = 1'b1;
                  state_in      = ST_PREFIX;
               end
            end
         end
         ST_SCAT_A: begin
            cmd.sorting = 1'b1;
            cmd.scat_a  = 1'b1;
            state_in    = ST_SCAT_B;
         end
         ST_SCAT_B: begin
            cmd.sorting = 1'b1;
            cmd.scat_b  = 1'b1;
            if (!status.scat_done) begin
               state_in = ST_SCAT_A;
            end else if (status.pass_last) begin
               cmd.finish = 1'b1;
               state_in   = ST_RD_WAIT;
            end else begin
               cmd.next_pass = 1'b1;
               state_in      = ST_PREFIX;
            end
         end
         ST_RD_WAIT: begin
            state_in = ST_RD_DATA;
         end
         ST_RD_DATA: begin
            cmd.rd_capture = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/lsdrs_datapath.sv -----
// ----------------------------------------------------------------------------
// lsdrs_datapath
// Ping-pong record stores, per-pass histograms, offset table, counters and
// the registered response word.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdrs_datapath
   import lsdrs_pkg::*;
#(
   parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
   parameter int DIGIT_PASSES = DIGIT_PASSES_DEF
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  ctl_cmd_type            cmd,
   output ctl_status_type         status,
   input  wire logic [REC_W-1:0]  req_record,
   output logic                   rsp_valid,
   output logic [REC_W-1:0]       rsp_sorted_record,
   output logic                   rsp_last,
   output logic                   rsp_empty_res,
   output logic                   rsp_overflow
);

   localparam int   CW        = $clog2(MAX_RECORDS + 1);
   localparam int   AW        = $clog2(MAX_RECORDS);
   localparam int   PW        = (DIGIT_PASSES > 1) ? $clog2(DIGIT_PASSES) : 1;
   localparam logic FINAL_SEL = 1'(DIGIT_PASSES % 2);

   // control registers
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rdpos_ff, rdpos_in;
   logic               sorted_ff, sorted_in;
   logic               ovf_ff, ovf_in;
   logic [PW-1:0]      pass_ff, pass_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [CW-1:0]      rec_idx_ff, rec_idx_in;
   logic               pfx_v_ff, pfx_v_in;
   logic               ld_ok_ff, ld_ok_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [CW-1:0]      sum_ff, sum_in;
   logic [DIGIT_W-1:0] pfx_bin_ff, pfx_bin_in;
   logic [DIGIT_W-1:0] ld_dig_ff [DIGIT_PASSES];
   logic [DIGIT_W-1:0] ld_dig_in [DIGIT_PASSES];
   logic [REC_W-1:0]   rec_ff, rec_in;
   logic [DIGIT_W-1:0] dig_ff, dig_in;
   logic [REC_W-1:0]   rsp_rec_ff, rsp_rec_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   // record stores
   logic [REC_W-1:0]   store0_ff [MAX_RECORDS];
   logic [REC_W-1:0]   store1_ff [MAX_RECORDS];
   logic [REC_W-1:0]   st0_q_ff, st1_q_ff;
   logic               st0_we, st1_we;
   logic [AW-1:0]      st0_wa, st1_wa, rd_addr;
   logic [REC_W-1:0]   st0_wd;
   logic [REC_W-1:0]   src_q;

   // offset table
   logic [CW-1:0]      off_mem_ff [DIGIT_VALUES];
   logic [CW-1:0]      off_q_ff;
   logic               off_we;
   logic [DIGIT_W-1:0] off_wa, off_ra;
   logic [CW-1:0]      off_wd;

   // histograms, one per pass
   logic               hist_we [DIGIT_PASSES];
   logic [DIGIT_W-1:0] hist_wa [DIGIT_PASSES];
   logic [CW-1:0]      hist_wd [DIGIT_PASSES];
   logic [DIGIT_W-1:0] hist_ra [DIGIT_PASSES];
   logic [CW-1:0]      hist_q_ff [DIGIT_PASSES];

   // load decode
   logic               full;
   logic [CW-1:0]      store_idx;
   logic [DIGIT_W-1:0] scan_dig;

   assign store_idx = sorted_ff ? '0 : count_ff;
   assign full      = !sorted_ff && (count_ff == CW'(MAX_RECORDS));
   assign rd_addr   = cmd.sorting ? rec_idx_ff[AW-1:0] : rdpos_ff[AW-1:0];
   assign src_q     = (cmd.sorting ? pass_ff[0] : FINAL_SEL) ? st1_q_ff : st0_q_ff;
   assign scan_dig  = digit_of(src_q, 2'(pass_ff));

   // record store ports: store 0 takes loads and odd-pass scatter,
   // store 1 takes even-pass scatter
   always_comb begin
      st0_we = 1'b0;
      st0_wa = store_idx[AW-1:0];
      st0_wd = req_record;
      if (cmd.load && !full) begin
         st0_we = 1'b1;
      end else if (cmd.scat_b && pass_ff[0]) begin
         st0_we = 1'b1;
         st0_wa = off_q_ff[AW-1:0];
         st0_wd = rec_ff;
      end
      st1_we = cmd.scat_b && !pass_ff[0];
      st1_wa = off_q_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (st0_we) begin
         store0_ff[st0_wa] <= st0_wd;
      end
      st0_q_ff <= store0_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (st1_we) begin
         store1_ff[st1_wa] <= rec_ff;
      end
      st1_q_ff <= store1_ff[rd_addr];
   end

   // offset table: prefix sum writes, scatter reads and bumps
   always_comb begin
      off_we = 1'b0;
      off_wa = pfx_bin_ff;
      off_wd = sum_ff;
      off_ra = scan_dig;
      if (cmd.pfx_step && pfx_v_ff) begin
         off_we = 1'b1;
      end else if (cmd.scat_b) begin
         off_we = 1'b1;
         off_wa = dig_ff;
         off_wd = CW'(off_q_ff + CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem_ff[off_wa] <= off_wd;
      end
      off_q_ff <= off_mem_ff[off_ra];
   end

   // histogram ports: clear after reset, increment on load,
   // clear-behind during the prefix sum
   always_comb begin
      for (int p = 0; p < DIGIT_PASSES; p++) begin
         hist_ra[p] = cmd.load ? digit_of(req_record, 2'(p)) : bin_ff[DIGIT_W-1:0];
         hist_we[p] = 1'b0;
         hist_wa[p] = bin_ff[DIGIT_W-1:0];
         hist_wd[p] = '0;
         if (cmd.clr_step) begin
            hist_we[p] = 1'b1;
         end else if (cmd.load_inc && ld_ok_ff) begin
            hist_we[p] = 1'b1;
            hist_wa[p] = ld_dig_ff[p];
            hist_wd[p] = CW'(hist_q_ff[p] + CW'(1));
         end else if (cmd.pfx_step && pfx_v_ff && (pass_ff == PW'(p))) begin
            hist_we[p] = 1'b1;
            hist_wa[p] = pfx_bin_ff;
         end
      end
   end

   for (genvar g = 0; g < DIGIT_PASSES; g++) begin : g_hist
      logic [CW-1:0] hist_mem_ff [DIGIT_VALUES];

      always_ff @(posedge clock) begin
         if (hist_we[g]) begin
            hist_mem_ff[hist_wa[g]] <= hist_wd[g];
         end
         hist_q_ff[g] <= hist_mem_ff[hist_ra[g]];
      end
   end

   // counters, flags and response word
   always_comb begin
      count_in     = count_ff;
      rdpos_in     = rdpos_ff;
      sorted_in    = sorted_ff;
      ovf_in       = ovf_ff;
      pass_in      = pass_ff;
      bin_in       = bin_ff;
      rec_idx_in   = rec_idx_ff;
      pfx_v_in     = 1'b0;
      ld_ok_in     = ld_ok_ff;
      sum_in       = sum_ff;
      pfx_bin_in   = bin_ff[DIGIT_W-1:0];
      ld_dig_in    = ld_dig_ff;
      rec_in       = rec_ff;
      dig_in       = dig_ff;
      rsp_valid_in = cmd.rd_capture;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (cmd.clr_step) begin
         bin_in = BIN_W'(bin_ff + BIN_W'(1));
      end

      // load: a load after reading began opens a new set
      if (cmd.load) begin
         ld_ok_in = !full;
         for (int p = 0; p < DIGIT_PASSES; p++) begin
            ld_dig_in[p] = digit_of(req_record, 2'(p));
         end
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in  = CW'(store_idx + CW'(1));
            sorted_in = 1'b0;
            if (sorted_ff) begin
               rdpos_in = '0;
            end
         end
      end

      if (cmd.sort_init) begin
         pass_in    = '0;
         bin_in     = '0;
         rec_idx_in = '0;
         sum_in     = '0;
      end

      // prefix sum: read bin, write its offset and the running sum in the next cycle
      if (cmd.pfx_step) begin
         bin_in   = BIN_W'(bin_ff + BIN_W'(1));
         pfx_v_in = !bin_ff[BIN_W-1];
         if (pfx_v_ff) begin
            sum_in = CW'(sum_ff + hist_q_ff[pass_ff]);
         end
      end

      if (cmd.scat_a) begin
         rec_in     = src_q;
         dig_in     = scan_dig;
         rec_idx_in = CW'(rec_idx_ff + CW'(1));
      end

      if (cmd.next_pass) begin
         pass_in    = PW'(pass_ff + PW'(1));
         bin_in     = '0;
         rec_idx_in = '0;
         sum_in     = '0;
      end

      if (cmd.finish) begin
         sorted_in = 1'b1;
         pass_in   = '0;
      end

      // read response
      if (cmd.rd_capture) begin
         rsp_ovf_in = ovf_ff;
         if (rdpos_ff < count_ff) begin
            rsp_rec_in   = src_q;
            rsp_last_in  = (CW'(rdpos_ff + CW'(1)) == count_ff);
            rsp_empty_in = 1'b0;
            rdpos_in     = CW'(rdpos_ff + CW'(1));
         end else begin
            rsp_rec_in   = '0;
            rsp_last_in  = 1'b0;
            rsp_empty_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rdpos_ff     <= '0;
         sorted_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         pass_ff      <= '0;
         bin_ff       <= '0;
         rec_idx_ff   <= '0;
         pfx_v_ff     <= 1'b0;
         ld_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rdpos_ff     <= rdpos_in;
         sorted_ff    <= sorted_in;
         ovf_ff       <= ovf_in;
         pass_ff      <= pass_in;
         bin_ff       <= bin_in;
         rec_idx_ff   <= rec_idx_in;
         pfx_v_ff     <= pfx_v_in;
         ld_ok_ff     <= ld_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      pfx_bin_ff   <= pfx_bin_in;
      ld_dig_ff    <= ld_dig_in;
      rec_ff       <= rec_in;
      dig_ff       <= dig_in;
      rsp_rec_ff   <= rsp_rec_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // status to the sequencer
   assign status.clr_last  = (bin_ff == BIN_W'(DIGIT_VALUES - 1));
   assign status.pfx_end   = bin_ff[BIN_W-1];
   assign status.scat_done = (rec_idx_ff == count_ff);
   assign status.pass_last = (pass_ff == PW'(DIGIT_PASSES - 1));
   assign status.sorted    = sorted_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sorted_record = rsp_rec_ff;
   assign rsp_last          = rsp_last_ff;
   assign rsp_empty_res     = rsp_empty_ff;
   assign rsp_overflow      = rsp_ovf_ff;

endmodule

`default_nettype wire

// ----- design/lsd_radix_sort_24bit_key_core.sv -----
// ----------------------------------------------------------------------------
// lsd_radix_sort_24bit_key_core
// Stable LSD radix sorter for 64-bit records on an 8-bit-per-digit key.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A load (req_op = 0)
// first writes the record store and reads the histogram bins, then writes
// the incremented bins back with busy high (ST_LOAD_INC). A read
// (req_op = 1) on a sorted set keeps busy high in ST_RD_WAIT and ST_RD_DATA,
// and its response word appears on the rsp_ ports, marked by rsp_valid, for
// exactly one cycle right after; the receiver cannot hold it off, and a new
// request may be taken while it shows.
// The first read after loading a set first runs the sort: per pass a prefix
// sum over the 256 histogram bins, then a scatter in which each record makes
// a dependent read and write of the offset table (ST_SCAT_A, ST_SCAT_B).
// After reset the block clears all 256 bins of each histogram with busy high.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_radix_sort_24bit_key_core
   import lsdrs_pkg::*;
#(
   parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
   parameter int DIGIT_PASSES = DIGIT_PASSES_DEF
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic              req_op,
   input  wire logic [REC_W-1:0]  req_record,
   output logic                   rsp_valid,
   output logic [REC_W-1:0]       rsp_sorted_record,
   output logic                   rsp_last,
   output logic                   rsp_empty_res,
   output logic                   rsp_overflow
);

   ctl_cmd_type    cmd;
   ctl_status_type status;

   // sequencer
   lsdrs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // stores, counters and response register
   lsdrs_datapath #(
      .MAX_RECORDS  (MAX_RECORDS),
      .DIGIT_PASSES (DIGIT_PASSES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_record        (req_record),
      .rsp_valid         (rsp_valid),
      .rsp_sorted_record (rsp_sorted_record),
      .rsp_last          (rsp_last),
      .rsp_empty_res     (rsp_empty_res),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

`default_nettype wire
